### hdl/kal_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kal_pkg
// Shared types and constants of the k-th ancestor lifting table.
// ---------------------------------------------------------------------------
package kal_pkg;

    localparam int FIELD_W     = 10;
    localparam int NODES_DEF   = 1024;
    localparam int LEVELS_DEF  = 10;

    localparam logic [FIELD_W-1:0] DEPTH_MAX = '1;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [FIELD_W-1:0] node;
        logic [FIELD_W-1:0] parent;
        logic [FIELD_W-1:0] k;
    } in_item_t;

    typedef struct packed {
        logic [FIELD_W-1:0] ancestor;
        logic               found;
    } out_item_t;

endpackage

### hdl/kal_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kal_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// A read of the address being written returns the old contents.
// ---------------------------------------------------------------------------
module kal_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hdl/kth_ancestor_lifting_table.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kth_ancestor_lifting_table
// Binary-lifting ancestor table with add and k-th ancestor query items.
// ---------------------------------------------------------------------------
// One item is worked on at a time. The jump table sits in a single RAM with
// one read and one write port, and each lifting level is one chained read of
// that port. A query steps through the levels, jumping where k has a bit set,
// then loads the result register once the consumer can take it. An add on an
// out-of-range node is dropped and such a query returns a miss. Adds give no
// result. Nodes must be added parent before child; the RAMs need no clearing
// after reset, so the block accepts items as soon as reset is released.
// ---------------------------------------------------------------------------
module kth_ancestor_lifting_table #(
    parameter int NODES  = kal_pkg::NODES_DEF,
    parameter int LEVELS = kal_pkg::LEVELS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  kal_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_ready,
    output kal_pkg::out_item_t result
);

    import kal_pkg::*;

    localparam int NW = $clog2(NODES);
    localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int AW = NW + LW;
    localparam int QL = (LEVELS < FIELD_W) ? LEVELS : FIELD_W;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_ROOT = 8'b0000_0010,
        S_ADEP = 8'b0000_0100,
        S_A0   = 8'b0000_1000,
        S_A1   = 8'b0001_0000,
        S_Q0   = 8'b0010_0000,
        S_QW   = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [LW-1:0]       lvl_reg, lvl_next;
    logic [NW-1:0]       cur_reg, cur_next;
    logic [FIELD_W-1:0]  node_reg, par_reg, k_reg;
    logic                fwd_hit_reg, fwd_hit_next;
    logic [FIELD_W-1:0]  fwd_data_reg, fwd_data_next;
    out_item_t           res_reg, res_next;
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_reg;

    logic                accept;
    logic                load_out;
    logic [NW-1:0]       node_idx;
    logic [FIELD_W-1:0]  eff;
    logic [NW-1:0]       eff_idx;
    logic [NW-1:0]       walk_idx;
    logic [FIELD_W-1:0]  k_shift;
    logic                last_add;
    logic                last_query;
    logic                found;

    logic                j_we, j_re;
    logic [AW-1:0]       j_waddr, j_raddr;
    logic [FIELD_W-1:0]  j_wdata, j_rdata;
    logic                d_we, d_re;
    logic [NW-1:0]       d_waddr, d_raddr;
    logic [FIELD_W-1:0]  d_wdata, d_rdata;

    function automatic logic in_range(input logic [FIELD_W-1:0] v);
        in_range = 32'(v) < NODES;
    endfunction

    // table values outside the node range point at node 0
    function automatic logic [NW-1:0] clamp_idx(input logic [FIELD_W-1:0] v);
        clamp_idx = in_range(v) ? NW'(v) : '0;
    endfunction

    kal_ram #(
        .WIDTH (FIELD_W),
        .DEPTH (NODES * (2 ** LW))
    ) u_jump_ram (
        .clk   (clk),
        .we    (j_we),
        .waddr (j_waddr),
        .wdata (j_wdata),
        .re    (j_re),
        .raddr (j_raddr),
        .rdata (j_rdata)
    );

    kal_ram #(
        .WIDTH (FIELD_W),
        .DEPTH (NODES)
    ) u_depth_ram (
        .clk   (clk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (d_wdata),
        .re    (d_re),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    assign item_ready   = (state_reg == S_IDLE);
    assign accept       = item_valid && item_ready;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign node_idx   = clamp_idx(node_reg);
    // read of the entry written in the previous cycle takes the forwarded value
    assign eff        = fwd_hit_reg ? fwd_data_reg : j_rdata;
    assign eff_idx    = clamp_idx(eff);
    assign k_shift    = k_reg >> lvl_reg;
    assign walk_idx   = k_shift[0] ? eff_idx : cur_reg;
    assign last_add   = (lvl_reg == LW'(LEVELS - 1));
    assign last_query = (lvl_reg == LW'(QL - 1));
    assign found      = !(k_reg > d_rdata);
    assign load_out   = (state_reg == S_OUT) && (!out_valid_reg || result_ready);

    always_comb
    begin
        state_next    = state_reg;
        lvl_next      = lvl_reg;
        cur_next      = cur_reg;
        fwd_hit_next  = 1'b0;
        fwd_data_next = fwd_data_reg;
        res_next      = res_reg;
        j_we          = 1'b0;
        j_waddr       = {node_idx, lvl_reg};
        j_wdata       = eff;
        j_re          = 1'b0;
        j_raddr       = {eff_idx, lvl_reg};
        d_we          = 1'b0;
        d_waddr       = node_idx;
        d_wdata       = '0;
        d_re          = 1'b0;
        d_raddr       = node_idx;

        case (state_reg)
            S_IDLE:
            begin
                lvl_next = '0;
                if (item_valid)
                begin
                    if (item.cmd == CMD_ADD)
                    begin
                        if (in_range(item.node) && in_range(item.parent))
                        begin
                            state_next = (item.node == item.parent) ? S_ROOT : S_ADEP;
                        end
                    end
                    else if (in_range(item.node))
                    begin
                        state_next = S_Q0;
                    end
                    else
                    begin
                        res_next   = '0;
                        state_next = S_OUT;
                    end
                end
            end

            S_ROOT:
            begin
                // a root points to itself at every level
                j_we    = 1'b1;
                j_wdata = node_reg;
                d_we    = 1'b1;
                d_wdata = '0;
                if (last_add)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    lvl_next = lvl_reg + LW'(1);
                end
            end

            S_ADEP:
            begin
                d_re       = 1'b1;
                d_raddr    = clamp_idx(par_reg);
                state_next = S_A0;
            end

            S_A0:
            begin
                d_we    = 1'b1;
                d_wdata = (d_rdata == DEPTH_MAX) ? DEPTH_MAX : d_rdata + FIELD_W'(1);
                j_we    = 1'b1;
                j_waddr = {node_idx, LW'(0)};
                j_wdata = par_reg;
                j_re    = 1'b1;
                j_raddr = {clamp_idx(par_reg), LW'(0)};
                lvl_next = LW'(1);
                state_next = (LEVELS == 1) ? S_IDLE : S_A1;
            end

            S_A1:
            begin
                j_we = 1'b1;
                if (last_add)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    j_re          = 1'b1;
                    fwd_hit_next  = (eff_idx == node_idx);
                    fwd_data_next = eff;
                    lvl_next      = lvl_reg + LW'(1);
                end
            end

            S_Q0:
            begin
                d_re       = 1'b1;
                j_re       = 1'b1;
                j_raddr    = {node_idx, LW'(0)};
                cur_next   = node_idx;
                lvl_next   = '0;
                state_next = S_QW;
            end

            S_QW:
            begin
                cur_next = walk_idx;
                if (last_query)
                begin
                    res_next.found    = found;
                    res_next.ancestor = found ? FIELD_W'(walk_idx) : '0;
                    state_next        = S_OUT;
                end
                else
                begin
                    j_re     = 1'b1;
                    j_raddr  = {walk_idx, lvl_reg + LW'(1)};
                    lvl_next = lvl_reg + LW'(1);
                end
            end

            S_OUT:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fwd_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fwd_hit_reg   <= fwd_hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_reg      <= lvl_next;
        cur_reg      <= cur_next;
        fwd_data_reg <= fwd_data_next;
        res_reg      <= res_next;
        if (accept)
        begin
            node_reg <= item.node;
            par_reg  <= item.parent;
            k_reg    <= item.k;
        end
        if (load_out)
        begin
            out_reg <= res_reg;
        end
    end

endmodule

### hdl/kal_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kal_checker
// Port-level checks on the k-th ancestor lifting table, bound to the top.
// ---------------------------------------------------------------------------
module kal_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_ready,
    input kal_pkg::in_item_t  item,
    input logic               result_valid,
    input logic               result_ready,
    input kal_pkg::out_item_t result
);

    import kal_pkg::*;

    // a waiting result item holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result item changed while stalled");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.found |-> result.ancestor == '0)
        else $error("ancestor not zero on a miss");

    // results are loaded only while the block is busy with an item
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> !$past(item_ready))
        else $error("result appeared while the block was idle");

    a_add_silent: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item.cmd == CMD_ADD && !result_valid
        |=> !result_valid)
        else $error("add item produced a result");

endmodule

bind kth_ancestor_lifting_table kal_checker u_kal_checker (.*);
